// ===== rtl/tvbs_pkg.sv =====
// Shared types and constants for the transformed vertex bounding sphere block.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tvbs_pkg;

  localparam int CoordW = 32;
  localparam int FracB  = 16;
  localparam int AccW   = 2 * CoordW + 2;
  localparam int NumW   = CoordW + FracB;

  localparam logic [CoordW-1:0] COORD_MAX = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] COORD_MIN = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [CoordW-1:0] COORD_ONE = CoordW'(1) << FracB;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [1:0]               row_index;
    logic signed [CoordW-1:0] val_a;
    logic signed [CoordW-1:0] val_b;
    logic signed [CoordW-1:0] val_c;
    logic signed [CoordW-1:0] val_d;
    logic                     last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [CoordW-2:0]        radius;
    logic                     saturated;
  } out_item_t;

  // Classified work item handed from the front to the back.
  typedef struct packed {
    logic              is_vertex;
    logic              last;
    logic [1:0]        row;
    logic [CoordW-1:0] a;
    logic [CoordW-1:0] b;
    logic [CoordW-1:0] c;
    logic [CoordW-1:0] d;
  } op_t;

endpackage
`default_nettype wire

// ===== rtl/tvbs_front.sv =====
// Front end: accepts input beats, classifies them and queues them for the back end.
// Depends on tvbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tvbs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tvbs_pkg::in_item_t in_data,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output tvbs_pkg::op_t         q_op
);

  tvbs_pkg::op_t mem_r [2];
  logic          wptr_r;
  logic          rptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  tvbs_pkg::op_t op_in;

  always_comb begin
    op_in.is_vertex = (in_data.kind == tvbs_pkg::KIND_VERTEX);
    op_in.last      = op_in.is_vertex & in_data.last_vertex;
    op_in.row       = in_data.row_index;
    op_in.a         = in_data.val_a;
    op_in.b         = in_data.val_b;
    op_in.c         = in_data.val_c;
    op_in.d         = in_data.val_d;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_op     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tvbs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the perspective divide.
// Depends on tvbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tvbs_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tvbs_pkg::NumW-1:0]   num,
  input  wire logic [tvbs_pkg::CoordW-1:0] den,
  output logic                           busy,
  output logic                           done,
  output logic [tvbs_pkg::NumW-1:0]        quo
);

  localparam int CntW = $clog2(tvbs_pkg::NumW);

  logic [tvbs_pkg::NumW-1:0]   quo_r;
  logic [tvbs_pkg::CoordW-1:0] rem_r;
  logic [tvbs_pkg::CoordW-1:0] den_r;
  logic [CntW-1:0]             cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [tvbs_pkg::CoordW:0]   rem_sh;
  logic                        qbit;
  logic [tvbs_pkg::CoordW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[tvbs_pkg::NumW-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_sub = qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CntW'(tvbs_pkg::NumW - 1);
    end else if (busy_r) begin
      rem_r <= rem_sub[tvbs_pkg::CoordW-1:0];
      quo_r <= {quo_r[tvbs_pkg::NumW-2:0], qbit};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tvbs_back.sv =====
// Back end: matrix store, transform MAC, divide sequencing, extremes, sphere and result register.
// Depends on tvbs_pkg and tvbs_div.
`timescale 1ns / 1ps
`default_nettype none
module tvbs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire tvbs_pkg::op_t  q_op,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tvbs_pkg::out_item_t out_data
);

  localparam int CW = tvbs_pkg::CoordW;
  localparam int FB = tvbs_pkg::FracB;
  localparam int AW = tvbs_pkg::AccW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_SAT   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_SQM   = 4'd7;
  localparam logic [3:0] S_SQA   = 4'd8;
  localparam logic [3:0] S_ROOT  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]            state_r;
  logic [CW-1:0]         mat_r [16];
  logic [CW-1:0]         vx_r [3];
  logic [CW-1:0]         t_r [4];
  logic [CW-1:0]         min_r [3];
  logic [CW-1:0]         max_r [3];
  logic [CW-1:0]         c_r [3];
  logic                  last_r;
  logic                  ovf_r;
  logic [1:0]            i_r, j_r, k_r;
  logic signed [AW-1:0]  acc_r;
  logic signed [AW-1:0]  prod_r;
  logic [CW-1:0]         p_r;
  logic [2*CW-1:0]       sq_r;
  logic [2*CW-1:0]       sqn_r;
  logic [CW-1:0]         root_r;
  logic [CW+1:0]         rem_r;
  logic [4:0]            cnt_r;
  logic                  out_valid_r;
  tvbs_pkg::out_item_t   out_r;

  // shared multiplier
  logic signed [CW:0]    mul_a, mul_b;
  logic signed [AW-1:0]  product;
  // center / offset for axis k
  logic signed [CW:0]    sum33;
  logic [CW-1:0]         cen;
  logic signed [CW:0]    d33;
  // transform saturation
  logic                  acc_ok;
  logic [CW-1:0]         acc_sat;
  // divider
  logic                  div_start, div_busy, div_done;
  logic [tvbs_pkg::NumW-1:0] div_quo;
  logic [CW-1:0]         abs_x, abs_w;
  logic                  q_neg;
  logic [CW-1:0]         quo_p;
  logic                  quo_ovf;
  // root step
  logic [CW+3:0]         rem_sh, trial;
  logic                  rbit;
  logic                  emit;
  logic [CW-1:0]         wk;

  always_comb begin
    sum33 = $signed({max_r[k_r][CW-1], max_r[k_r]}) + $signed({min_r[k_r][CW-1], min_r[k_r]});
    cen   = sum33[CW:1];
    d33   = $signed({cen[CW-1], cen}) - $signed({min_r[k_r][CW-1], min_r[k_r]});
    if (state_r == S_MUL) begin
      mul_a = $signed({vx_r[i_r][CW-1], vx_r[i_r]});
      mul_b = $signed({mat_r[{i_r, j_r}][CW-1], mat_r[{i_r, j_r}]});
    end else begin
      mul_a = $signed({1'b0, d33[CW-1:0]});
      mul_b = $signed({1'b0, d33[CW-1:0]});
    end
    product = mul_a * mul_b;
  end

  always_comb begin
    acc_ok  = (&acc_r[AW-1:FB+CW-1]) | ~(|acc_r[AW-1:FB+CW-1]);
    acc_sat = acc_ok ? acc_r[FB+CW-1:FB]
                     : (acc_r[AW-1] ? tvbs_pkg::COORD_MIN : tvbs_pkg::COORD_MAX);
  end

  always_comb begin
    wk      = t_r[k_r];
    abs_x   = wk[CW-1] ? (~wk + 1'b1) : wk;
    abs_w   = t_r[3][CW-1] ? (~t_r[3] + 1'b1) : t_r[3];
    q_neg   = wk[CW-1] ^ t_r[3][CW-1];
    div_start = (state_r == S_DIV) && (t_r[3] != '0);
    if (q_neg) begin
      quo_ovf = (div_quo > {{(tvbs_pkg::NumW-CW){1'b0}}, tvbs_pkg::COORD_MIN});
      quo_p   = quo_ovf ? tvbs_pkg::COORD_MIN : (~div_quo[CW-1:0] + 1'b1);
    end else begin
      quo_ovf = (div_quo > {{(tvbs_pkg::NumW-CW){1'b0}}, tvbs_pkg::COORD_MAX});
      quo_p   = quo_ovf ? tvbs_pkg::COORD_MAX : div_quo[CW-1:0];
    end
  end

  tvbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({abs_x, {FB{1'b0}}}),
    .den   (abs_w),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    rem_sh = {rem_r, sqn_r[2*CW-1:2*CW-2]};
    trial  = {2'b00, root_r, 2'b01};
    rbit   = (rem_sh >= trial);
  end

  assign q_pop     = q_valid && (state_r == S_IDLE);
  assign emit      = (state_r == S_EMIT) && !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      for (int n = 0; n < 16; n++) begin
        mat_r[n] <= (n % 5 == 0) ? tvbs_pkg::COORD_ONE : '0;
      end
      for (int n = 0; n < 3; n++) begin
        min_r[n] <= tvbs_pkg::COORD_MAX;
        max_r[n] <= tvbs_pkg::COORD_MIN;
      end
    end else begin
      if (out_valid_r && !out_stall && !emit) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_op.is_vertex) begin
              vx_r[0] <= q_op.a;
              vx_r[1] <= q_op.b;
              vx_r[2] <= q_op.c;
              last_r  <= q_op.last;
              i_r     <= 2'd0;
              j_r     <= 2'd0;
              sq_r    <= '0;
              acc_r   <= $signed({{(AW-CW-FB){mat_r[12][CW-1]}}, mat_r[12], {FB{1'b0}}});
              state_r <= S_MUL;
            end else begin
              mat_r[{q_op.row, 2'd0}] <= q_op.a;
              mat_r[{q_op.row, 2'd1}] <= q_op.b;
              mat_r[{q_op.row, 2'd2}] <= q_op.c;
              mat_r[{q_op.row, 2'd3}] <= q_op.d;
            end
          end
        end
        S_MUL: begin
          prod_r  <= product;
          state_r <= S_ADD;
        end
        S_ADD: begin
          acc_r <= acc_r + prod_r;
          if (i_r == 2'd2) begin
            state_r <= S_SAT;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_SAT: begin
          t_r[j_r] <= acc_sat;
          if (!acc_ok) ovf_r <= 1'b1;
          i_r <= 2'd0;
          if (j_r == 2'd3) begin
            k_r     <= 2'd0;
            state_r <= S_DIV;
          end else begin
            j_r     <= j_r + 1'b1;
            acc_r   <= $signed({{(AW-CW-FB){mat_r[{2'd3, j_r + 2'd1}][CW-1]}},
                                mat_r[{2'd3, j_r + 2'd1}], {FB{1'b0}}});
            state_r <= S_MUL;
          end
        end
        S_DIV: begin
          if (t_r[3] == '0) begin
            // zero w: saturate toward the dividend's sign
            p_r     <= wk[CW-1] ? tvbs_pkg::COORD_MIN : tvbs_pkg::COORD_MAX;
            ovf_r   <= 1'b1;
            state_r <= S_UPD;
          end else begin
            state_r <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            p_r <= quo_p;
            if (quo_ovf) ovf_r <= 1'b1;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if ($signed(p_r) < $signed(min_r[k_r])) min_r[k_r] <= p_r;
          if ($signed(max_r[k_r]) < $signed(p_r)) max_r[k_r] <= p_r;
          if (k_r == 2'd2) begin
            k_r     <= 2'd0;
            state_r <= last_r ? S_SQM : S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_DIV;
          end
        end
        S_SQM: begin
          prod_r   <= product;
          c_r[k_r] <= cen;
          state_r  <= S_SQA;
        end
        S_SQA: begin
          sq_r <= sq_r + prod_r[2*CW-1:0];
          if (k_r == 2'd2) begin
            sqn_r   <= sq_r + prod_r[2*CW-1:0];
            root_r  <= '0;
            rem_r   <= '0;
            cnt_r   <= 5'd31;
            state_r <= S_ROOT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SQM;
          end
        end
        S_ROOT: begin
          rem_r  <= rbit ? (CW+2)'(rem_sh - trial) : rem_sh[CW+1:0];
          root_r <= {root_r[CW-2:0], rbit};
          sqn_r  <= {sqn_r[2*CW-3:0], 2'b00};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == 5'd0) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_valid_r        <= 1'b1;
            out_r.center_x     <= c_r[0];
            out_r.center_y     <= c_r[1];
            out_r.center_z     <= c_r[2];
            out_r.radius       <= root_r[CW-1] ? {(CW-1){1'b1}} : root_r[CW-2:0];
            out_r.saturated    <= ovf_r | root_r[CW-1];
            ovf_r              <= 1'b0;
            for (int n = 0; n < 3; n++) begin
              min_r[n] <= tvbs_pkg::COORD_MAX;
              max_r[n] <= tvbs_pkg::COORD_MIN;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_dwait_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWAIT) |-> (div_busy || div_done)) else $error("waiting on idle divider");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && !ovf_r && state_r == S_IDLE)) else $error("emit did not settle");

endmodule
`default_nettype wire

// ===== rtl/transformed_vertex_bounding_sphere_top.sv =====
// A matrix-row beat is written into the matrix store by the back end's idle state after queueing.
// A vertex is transformed as 4 columns on one shared 33x33 multiplier (a multiply, then an add, per term),
// then takes 3 serial divides on a one-bit-per-cycle divider (a zero w skips the divider and saturates).
// A last vertex adds 3 squares, a 32-step square root and a result load, plus any
// output stall. Throughput is one item at a time in the back end; a 2-deep queue holds arrivals.
// Reset: synchronous; matrix returns to identity, extremes and saturation flag clear.
`timescale 1ns / 1ps
`default_nettype none
module transformed_vertex_bounding_sphere_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tvbs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tvbs_pkg::out_item_t     out_data
);

  logic          q_valid;
  logic          q_pop;
  tvbs_pkg::op_t q_op;

  tvbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op)
  );

  tvbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (q_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
